// ===== src/sitda_pkg.sv =====
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: shared package
// Types, constants and the binary-to-BCD step function used by the converter
// and the character emitter.
// ----------------------------------------------------------------------------
package sitda_pkg;

   localparam int unsigned VALUE_WIDTH   = 32;
   localparam int unsigned NUM_DIGITS    = 10;
   localparam int unsigned BCD_WIDTH     = NUM_DIGITS * 4;
   localparam int unsigned BITS_PER_STEP = 4;
   localparam int unsigned CONV_STEPS    = VALUE_WIDTH / BITS_PER_STEP;
   localparam int unsigned STEP_CNT_W    = $clog2(CONV_STEPS);
   localparam int unsigned DIGIT_IDX_W   = $clog2(NUM_DIGITS);
   localparam int unsigned CHAR_WIDTH    = 7;

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 7'd48;
   localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 7'd45;

   typedef enum logic [1:0] {
      CONV_IDLE,
      CONV_RUN,
      CONV_HOLD
   } conv_state_type;

   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_SIGN,
      EMIT_DIGIT
   } emit_state_type;

   // Converted value handed from the converter to the emitter.
   typedef struct packed {
      logic                   neg;
      logic [DIGIT_IDX_W-1:0] top_idx;
      logic [BCD_WIDTH-1:0]   bcd;
   } conv_result_type;

   // One shift-and-add-3 step: correct every digit of five or more, then
   // shift the whole BCD word left by one with a new binary bit at the bottom.
   function automatic logic [BCD_WIDTH-1:0] dabble_step(
      input logic [BCD_WIDTH-1:0] bcd,
      input logic                 bit_in
   );
      logic [BCD_WIDTH-1:0] adj;
      adj = bcd;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd[i*4 +: 4] >= 4'd5) begin
            adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
         end
      end
      return {adj[BCD_WIDTH-2:0], bit_in};
   endfunction

endpackage

// ===== src/signed_int_to_decimal_ascii.sv =====
// Each accepted input transaction runs through eight four-bit BCD conversion steps,
// then its characters leave one per cycle while rsp_tready is high, through the
// one-character output register. A value gives 1 to 11 characters; the converter can
// take the next value while the previous one is still being sent.
// Reset (synchronous, active high) empties both stages; no state is kept between values.
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: top level
// Converts a signed 32-bit integer into its decimal ASCII text, one
// character per result transaction, with tlast on the final character.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [6:0] char_code, [7] zero fill
   output logic        rsp_tlast    // last character of the value's text
);
   import sitda_pkg::*;

   // Hand-off between the converter and the emitter. The converter holds its
   // finished digits until the emitter has taken them, so the next value can
   // be converted while the previous one is still being sent out.
   conv_result_type conv_res;
   logic            conv_valid;
   logic            conv_ready;
   logic [6:0]      char_code;

   // The converter negates negative values into an unsigned 32-bit magnitude,
   // so the most negative value needs no special handling, and then runs the
   // shift-and-add-3 algorithm four bits per cycle until all 32 bits are in.
   sitda_bcd_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_value  (req_tdata),
      .res_valid (conv_valid),
      .res_ready (conv_ready),
      .res       (conv_res)
   );

   // The emitter sends the minus sign first where needed, then the digits
   // from the highest non-zero one down to the units digit. Zero gives a
   // single '0' because the units digit is always sent.
   sitda_char_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (conv_valid),
      .in_ready  (conv_ready),
      .in_res    (conv_res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (char_code),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, char_code};

endmodule

// ===== src/sitda_bcd_conv.sv =====
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: BCD converter
// Takes the magnitude apart into decimal digits, four binary bits per cycle.
// ----------------------------------------------------------------------------
module sitda_bcd_conv (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [31:0]                in_value,
   output logic                       res_valid,
   input  logic                       res_ready,
   output sitda_pkg::conv_result_type res
);
   import sitda_pkg::*;

   conv_state_type         state_ff, state_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [STEP_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic [DIGIT_IDX_W-1:0] top_idx;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CONV_IDLE: if (in_valid) state_in = CONV_RUN;
         CONV_RUN:  if (cnt_ff == STEP_CNT_W'(CONV_STEPS - 1)) state_in = CONV_HOLD;
         CONV_HOLD: if (res_ready) state_in = CONV_IDLE;
         default:   state_in = CONV_IDLE;
      endcase
   end

   always_comb begin
      in_ready  = (state_ff == CONV_IDLE);
      res_valid = (state_ff == CONV_HOLD);
   end

   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      if (in_valid && in_ready) begin
         neg_in = in_value[VALUE_WIDTH-1];
         mag_in = in_value[VALUE_WIDTH-1] ? (~in_value + VALUE_WIDTH'(1)) : in_value;
         bcd_in = '0;
         cnt_in = '0;
      end else if (state_ff == CONV_RUN) begin
         bcd_in = bcd_ff;
         for (int b = 0; b < BITS_PER_STEP; b++) begin
            bcd_in = dabble_step(bcd_in, mag_ff[VALUE_WIDTH-1-b]);
         end
         mag_in = mag_ff << BITS_PER_STEP;
         cnt_in = cnt_ff + STEP_CNT_W'(1);
      end
   end

   // Highest non-zero digit; zero itself keeps a single digit.
   always_comb begin
      top_idx = '0;
      for (int i = 1; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) top_idx = DIGIT_IDX_W'(i);
      end
   end

   assign res.neg     = neg_ff;
   assign res.top_idx = top_idx;
   assign res.bcd     = bcd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CONV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

endmodule

// ===== src/sitda_char_emit.sv =====
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: character emitter
// Sends the sign and the digits, most significant first, through an output
// register.
// ----------------------------------------------------------------------------
module sitda_char_emit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  sitda_pkg::conv_result_type in_res,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [6:0]                 out_char,
   output logic                       out_last
);
   import sitda_pkg::*;

   emit_state_type         state_ff, state_in;
   logic [BCD_WIDTH-1:0]   digits_ff, digits_in;
   logic [DIGIT_IDX_W-1:0] ptr_ff, ptr_in;
   logic                   valid_ff, valid_in;
   logic [CHAR_WIDTH-1:0]  char_ff, char_in;
   logic                   last_ff, last_in;
   logic                   out_free;
   logic                   issue;
   logic [CHAR_WIDTH-1:0]  next_char;
   logic                   next_last;

   assign out_free = !valid_ff || out_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         EMIT_IDLE:  if (in_valid) state_in = in_res.neg ? EMIT_SIGN : EMIT_DIGIT;
         EMIT_SIGN:  if (out_free) state_in = EMIT_DIGIT;
         EMIT_DIGIT: if (out_free && ptr_ff == '0) state_in = EMIT_IDLE;
         default:    state_in = EMIT_IDLE;
      endcase
   end

   always_comb begin
      in_ready  = 1'b0;
      issue     = 1'b0;
      next_char = ASCII_MINUS;
      next_last = 1'b0;
      case (state_ff)
         EMIT_IDLE: begin
            in_ready = 1'b1;
         end
         EMIT_SIGN: begin
            issue = out_free;
         end
         EMIT_DIGIT: begin
            issue     = out_free;
            next_char = ASCII_ZERO | CHAR_WIDTH'(digits_ff[ptr_ff*4 +: 4]);
            next_last = (ptr_ff == '0);
         end
         default: begin
            in_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      digits_in = digits_ff;
      ptr_in    = ptr_ff;
      valid_in  = valid_ff;
      char_in   = char_ff;
      last_in   = last_ff;
      if (in_valid && in_ready) begin
         digits_in = in_res.bcd;
         ptr_in    = in_res.top_idx;
      end
      if (state_ff == EMIT_DIGIT && issue && ptr_ff != '0) begin
         ptr_in = ptr_ff - DIGIT_IDX_W'(1);
      end
      if (out_free) begin
         valid_in = issue;
         char_in  = next_char;
         last_in  = next_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EMIT_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      digits_ff <= digits_in;
      ptr_ff    <= ptr_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

endmodule

// ===== src/sitda_checker.sv =====
// ----------------------------------------------------------------------------
// Signed integer to decimal ASCII: port checker
// Watches the top level's ports and flags illegal result transactions and an input reopened after an accepted value.
// ----------------------------------------------------------------------------
module sitda_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);
   import sitda_pkg::*;

   logic is_minus;
   logic is_digit;

   assign is_minus = (rsp_tdata == {1'b0, ASCII_MINUS});
   assign is_digit = (rsp_tdata[7:4] == 4'h3) && (rsp_tdata[3:0] <= 4'd9);

   // The result channel is empty in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // An accepted value keeps the input closed in the next cycle while it is converted.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input open right after an accepted value");

   // A stalled result transaction keeps its character and flag.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Every character is a minus sign or a decimal digit.
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> is_minus || is_digit)
      else $error("illegal character code");

   // A minus sign is never flagged as the last character.
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && is_minus |-> !rsp_tlast)
      else $error("minus sign flagged as last");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (.*);
